[sv/blob_box_clustering_macros.svh]
// assertion macros shared by the blob box clustering rtl
`ifndef BLOB_BOX_CLUSTERING_MACROS_SVH
`define BLOB_BOX_CLUSTERING_MACROS_SVH
`ifndef ASSERT_OFF
// check that is skipped while reset is asserted
`define BBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// check that also covers the reset cycles
`define BBC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define BBC_ASSERT(label, prop, msg)
`define BBC_ASSERT_RST(label, prop, msg)
`endif
`endif

[sv/bbc_pkg.sv]
package bbc_pkg;

    // field widths
    localparam int COORD_W = 11;
    localparam int PIX_W   = 8;
    localparam int EDGE_W  = 13;
    localparam int INDEX_W = 4;

    // register map, word index taken from paddr[2]
    localparam logic [0:0] REG_HOT_THRESHOLD = 1'b0;
    localparam logic [PIX_W-1:0] HOT_THRESHOLD_RST = 8'd32;

    typedef logic signed [EDGE_W-1:0] bbc_edge_t;

    // one box, margin included
    typedef struct packed {
        bbc_edge_t xmin;
        bbc_edge_t xmax;
        bbc_edge_t ymin;
        bbc_edge_t ymax;
    } bbc_box_t;

    // hot pixel travelling down the chain as its margin square
    typedef struct packed {
        logic     valid;
        bbc_box_t sq;
    } bbc_pix_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_EMIT
    } bbc_state_t;

endpackage

[sv/bbc_cell.sv]
module bbc_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  bbc_pkg::bbc_pix_t  pix_i,
    output bbc_pkg::bbc_pix_t  pix_o,
    input  logic               shift_en,
    input  bbc_pkg::bbc_box_t  up_box_i,
    input  logic               up_used_i,
    output bbc_pkg::bbc_box_t  box_o,
    output logic               used_o
);

    bbc_pkg::bbc_box_t box_reg, box_next;
    logic              used_reg, used_next;
    logic              pix_valid_reg, pix_valid_next;
    bbc_pkg::bbc_box_t pix_sq_reg;
    logic              overlap;
    logic              hit;
    logic              claim;

    // inclusive overlap of the pixel square with the held box
    always_comb begin
        overlap = used_reg
                  && (pix_i.sq.xmax >= box_reg.xmin) && (pix_i.sq.xmin <= box_reg.xmax)
                  && (pix_i.sq.ymax >= box_reg.ymin) && (pix_i.sq.ymin <= box_reg.ymax);
        hit   = pix_i.valid && overlap;
        claim = pix_i.valid && !used_reg;
    end

    // box update: shift toward the output, widen on hit, open on a free cell
    always_comb begin
        box_next = box_reg;
        if (shift_en) begin
            box_next = up_box_i;
        end else if (hit) begin
            if (pix_i.sq.xmin < box_reg.xmin) box_next.xmin = pix_i.sq.xmin;
            if (pix_i.sq.xmax > box_reg.xmax) box_next.xmax = pix_i.sq.xmax;
            if (pix_i.sq.ymin < box_reg.ymin) box_next.ymin = pix_i.sq.ymin;
            if (pix_i.sq.ymax > box_reg.ymax) box_next.ymax = pix_i.sq.ymax;
        end else if (claim) begin
            box_next = pix_i.sq;
        end
        used_next      = shift_en ? up_used_i : (used_reg | claim);
        // pixel moves on only past a used box it does not touch
        pix_valid_next = pix_i.valid && used_reg && !overlap;
    end

    // occupancy and pipeline valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= 1'b0;
            pix_valid_reg <= 1'b0;
        end else begin
            used_reg      <= used_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        box_reg    <= box_next;
        pix_sq_reg <= pix_i.sq;
    end

    assign box_o       = box_reg;
    assign used_o      = used_reg;
    assign pix_o.valid = pix_valid_reg;
    assign pix_o.sq    = pix_sq_reg;

endmodule

[sv/blob_box_clustering.sv]
// pixel request: one per cycle while s_tready is high, walks the box chain one cell per cycle;
//   its last possible box update is made by the last cell of the chain
// end of frame: s_tready low until the final result loads; first result valid
//   once the chain has drained (DRAIN state), then one per cycle
//   while m_tready is high, n boxes or one empty result
// reset (aresetn low, synchronous): boxes emptied, output valid cleared, threshold 32
`include "blob_box_clustering_macros.svh"

module blob_box_clustering #(
    parameter int BOX_MARGIN = 4,
    parameter int BOX_SLOTS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [10:0] pix_x, [21:11] pix_y, [29:22] frame_value, [37:30] ref_value, [39:38] zero
    input  logic [39:0] s_tdata,
    // [0] func
    input  logic [0:0]  s_tuser,
    // box stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] box_index, [16:4] box_xmin, [29:17] box_xmax, [42:30] box_ymin,
    // [55:43] box_ymax
    output logic [55:0] m_tdata,
    // [0] box_valid
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    localparam int NCELL = BOX_SLOTS - 1;
    localparam int CNT_W = $clog2(BOX_SLOTS);
    localparam bbc_pkg::bbc_edge_t MARGIN_E = bbc_pkg::bbc_edge_t'(BOX_MARGIN);

    logic [bbc_pkg::PIX_W-1:0] thr_reg, thr_next;
    bbc_pkg::bbc_state_t       state_reg, state_next;

    logic [bbc_pkg::COORD_W-1:0] pix_x, pix_y;
    logic [bbc_pkg::PIX_W-1:0]   frame_value, ref_value;
    logic                        in_acc;
    logic                        hot;
    logic                        cfg_wr;

    bbc_pkg::bbc_pix_t pix_chain [NCELL+1];
    bbc_pkg::bbc_box_t box_ext   [NCELL+1];
    logic [NCELL:0]    used_ext;
    logic [NCELL-1:0]  used_vec;
    logic [NCELL-1:0]  inflight_vec;
    logic              any_inflight;

    logic              out_load;
    logic              shift_en;
    logic              load_last;
    logic [CNT_W-1:0]  idx_reg, idx_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    bbc_pkg::bbc_box_t             out_box_reg;
    logic [bbc_pkg::INDEX_W-1:0]   out_idx_reg;
    logic                          out_flag_reg;
    logic                          out_last_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        thr_next = thr_reg;
        if (cfg_wr && (paddr[2:2] == bbc_pkg::REG_HOT_THRESHOLD)) begin
            thr_next = pwdata[bbc_pkg::PIX_W-1:0];
        end
        prdata = '0;
        if (paddr[2:2] == bbc_pkg::REG_HOT_THRESHOLD) begin
            prdata = {24'd0, thr_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= bbc_pkg::HOT_THRESHOLD_RST;
        end else begin
            thr_reg <= thr_next;
        end
    end

    // input unpacking and hot test
    assign pix_x       = s_tdata[10:0];
    assign pix_y       = s_tdata[21:11];
    assign frame_value = s_tdata[29:22];
    assign ref_value   = s_tdata[37:30];
    assign in_acc      = s_tvalid && s_tready;

    always_comb begin
        hot = {1'b0, frame_value} > ({1'b0, ref_value} + {1'b0, thr_reg});
        pix_chain[0].valid   = in_acc && !s_tuser[0] && hot;
        pix_chain[0].sq.xmin = $signed({2'b00, pix_x}) - MARGIN_E;
        pix_chain[0].sq.xmax = $signed({2'b00, pix_x}) + MARGIN_E;
        pix_chain[0].sq.ymin = $signed({2'b00, pix_y}) - MARGIN_E;
        pix_chain[0].sq.ymax = $signed({2'b00, pix_y}) + MARGIN_E;
    end

    // box chain, cell 0 faces the output
    assign used_ext[NCELL] = 1'b0;
    assign box_ext[NCELL]  = '0;

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        bbc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .pix_i     (pix_chain[i]),
            .pix_o     (pix_chain[i+1]),
            .shift_en  (shift_en),
            .up_box_i  (box_ext[i+1]),
            .up_used_i (used_ext[i+1]),
            .box_o     (box_ext[i]),
            .used_o    (used_ext[i])
        );
        assign inflight_vec[i] = pix_chain[i+1].valid;
    end

    assign used_vec     = used_ext[NCELL-1:0];
    assign any_inflight = |inflight_vec;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bbc_pkg::ST_IDLE: begin
                if (in_acc && s_tuser[0]) state_next = bbc_pkg::ST_DRAIN;
            end
            bbc_pkg::ST_DRAIN: begin
                if (!any_inflight) state_next = bbc_pkg::ST_EMIT;
            end
            bbc_pkg::ST_EMIT: begin
                if (out_load && load_last) state_next = bbc_pkg::ST_IDLE;
            end
            default: state_next = bbc_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = (state_reg == bbc_pkg::ST_IDLE);
        out_load  = (state_reg == bbc_pkg::ST_EMIT) && (!m_tvalid_reg || m_tready);
        shift_en  = out_load;
        load_last = !used_ext[1 % (NCELL + 1)] || !used_ext[0] || (NCELL == 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bbc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // result index
    always_comb begin
        idx_next = idx_reg;
        if (state_reg == bbc_pkg::ST_IDLE) begin
            idx_next = '0;
        end else if (out_load) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_box_reg  <= used_ext[0] ? box_ext[0] : '0;
            out_idx_reg  <= used_ext[0] ? bbc_pkg::INDEX_W'(idx_reg) : '0;
            out_flag_reg <= used_ext[0];
            out_last_reg <= load_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_box_reg.ymax, out_box_reg.ymin, out_box_reg.xmax,
                       out_box_reg.xmin, out_idx_reg};
    assign m_tuser  = out_flag_reg;
    assign m_tlast  = out_last_reg;

    // boxes always fill the chain from cell 0 without gaps
    `BBC_ASSERT(a_used_packed, ((used_vec + 1'b1) & used_vec) == '0, "box chain has a gap")
    // emission never overlaps a pixel still walking the chain
    `BBC_ASSERT(a_emit_drained, (state_reg == bbc_pkg::ST_EMIT) |-> !any_inflight, "emit with pixel in flight")
    // the list is empty once an emission run ends
    `BBC_ASSERT(a_cleared_after_emit, (state_reg == bbc_pkg::ST_EMIT && state_next == bbc_pkg::ST_IDLE) |=> (used_vec == '0), "boxes left after emission")
    // a loaded result without a box is always the final one
    `BBC_ASSERT(a_empty_is_last, (out_load && !used_ext[0]) |-> load_last, "empty result not marked last")
    // reset leaves the block idle with no result pending
    `BBC_ASSERT_RST(a_reset_idle, !aresetn |=> (state_reg == bbc_pkg::ST_IDLE && !m_tvalid), "not idle after reset")

endmodule
